// ----- sv/rtp3_pkg.sv -----
// rtp3_pkg: shared types, constants and the CORDIC angle table for the
// point transform block. No dependencies.
package rtp3_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int COEF_WIDTH = 18;
  localparam int CORDIC_STEPS = 24;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_WIDTH-1:0] angle_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } reg_idx_t;

  // Matrix builder status toward the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } mat_stat_t;

  function automatic logic signed [33:0] arc_of(input logic [4:0] i);
    case (i)
      5'd0: arc_of = 34'sd536870912;
      5'd1: arc_of = 34'sd316933406;
      5'd2: arc_of = 34'sd167458907;
      5'd3: arc_of = 34'sd85004756;
      5'd4: arc_of = 34'sd42667331;
      5'd5: arc_of = 34'sd21354465;
      5'd6: arc_of = 34'sd10679838;
      5'd7: arc_of = 34'sd5340245;
      5'd8: arc_of = 34'sd2670163;
      5'd9: arc_of = 34'sd1335087;
      5'd10: arc_of = 34'sd667544;
      5'd11: arc_of = 34'sd333772;
      5'd12: arc_of = 34'sd166886;
      5'd13: arc_of = 34'sd83443;
      5'd14: arc_of = 34'sd41722;
      5'd15: arc_of = 34'sd20861;
      5'd16: arc_of = 34'sd10430;
      5'd17: arc_of = 34'sd5215;
      5'd18: arc_of = 34'sd2608;
      5'd19: arc_of = 34'sd1304;
      5'd20: arc_of = 34'sd652;
      5'd21: arc_of = 34'sd326;
      5'd22: arc_of = 34'sd163;
      5'd23: arc_of = 34'sd81;
      default: arc_of = 34'sd0;
    endcase
  endfunction
endpackage

// ----- sv/rotate_translate_point_3d.sv -----
// rotate_translate_point_3d: world = R*local + T, R = Rz*Ry*Rx, Q16.16.
// An accepted input word passes the split, product, row-sum and result registers
// to the output word; one word per cycle sustained, stalls hold every stage in place.
// An angle write rebuilds R: three CORDIC runs, then a product and a sum step
// per coefficient; cfg_ready and in_tready are low while that runs. Synchronous
// active-low reset restores the identity matrix, zero angles and zero offsets.
module rotate_translate_point_3d import rtp3_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [95:0]                in_tdata,  // local_x, local_y, local_z
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [95:0]                out_tdata, // world_x, world_y, world_z
  output logic                       out_tuser  // clipped
);
  angle_t ax_r, ay_r, az_r, ax_nxt, ay_nxt, az_nxt;
  coord_t off_r [3];
  coord_t off_nxt [3];
  logic rebuild_r, rebuild_nxt;
  mat_stat_t mstat;
  coef_t coef [9];
  logic cfg_take;
  logic pipe_ready;
  coord_t wx, wy, wz;

  // hold configuration while the matrix is being rebuilt
  assign cfg_ready = !mstat.busy && !rebuild_r;
  assign cfg_take = cfg_valid && cfg_ready;

  always_comb begin
    ax_nxt = ax_r;
    ay_nxt = ay_r;
    az_nxt = az_r;
    off_nxt = off_r;
    rebuild_nxt = 1'b0;
    if (cfg_take) begin
      case (reg_idx_t'(cfg_index))
        REG_ANGLE_X: begin ax_nxt = cfg_data[ANGLE_WIDTH-1:0]; rebuild_nxt = 1'b1; end
        REG_ANGLE_Y: begin ay_nxt = cfg_data[ANGLE_WIDTH-1:0]; rebuild_nxt = 1'b1; end
        REG_ANGLE_Z: begin az_nxt = cfg_data[ANGLE_WIDTH-1:0]; rebuild_nxt = 1'b1; end
        REG_OFFSET_X: off_nxt[0] = cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y: off_nxt[1] = cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Z: off_nxt[2] = cfg_data[COORD_WIDTH-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      az_r <= '0;
      off_r <= '{default: '0};
      rebuild_r <= 1'b0;
    end else begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
      off_r <= off_nxt;
      rebuild_r <= rebuild_nxt;
    end
  end

  rtp3_matrix u_matrix (
    .clk(clk), .rst_n(rst_n), .start(rebuild_r),
    .angle_x(ax_r), .angle_y(ay_r), .angle_z(az_r),
    .stat(mstat), .coef(coef)
  );

  // input words wait while coefficients are in flux
  assign in_tready = pipe_ready && !mstat.busy && !rebuild_r;

  rtp3_point_pipe u_pipe (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid && !mstat.busy && !rebuild_r), .in_ready(pipe_ready),
    .px(in_tdata[31:0]), .py(in_tdata[63:32]), .pz(in_tdata[95:64]),
    .coef(coef), .off(off_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .wx(wx), .wy(wy), .wz(wz), .clip(out_tuser)
  );

  assign out_tdata = {wz, wy, wx};
endmodule

// ----- sv/rtp3_cordic.sv -----
// rtp3_cordic: iterative sine/cosine of a binary angle, one CORDIC step
// per cycle, Q16 results. Depends on rtp3_pkg.
module rtp3_cordic import rtp3_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  angle_t                      angle,
  output logic                        done,
  output logic signed [17:0]          sin_q16,
  output logic signed [17:0]          cos_q16
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } cst_t;

  cst_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic neg_r, neg_nxt;
  logic [1:0] spec_r, spec_nxt; // 0 cordic, 1 zero, 2 +quarter, 3 -quarter
  logic signed [17:0] s_r, c_r, s_nxt, c_nxt;
  logic done_r, done_nxt;

  logic signed [33:0] t0, zf, xs, ys, xr, yr;
  logic signed [33:0] rx, ry;
  logic signed [17:0] cv, sv;

  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF = 34'sd2147483648;

  function automatic logic signed [17:0] clampq(input logic signed [33:0] v);
    if (v > 34'sd65536) clampq = 18'sd65536;
    else if (v < -34'sd65536) clampq = -18'sd65536;
    else clampq = v[17:0];
  endfunction

  always_comb begin
    t0 = {{2{1'b0}}, angle, {(32-ANGLE_WIDTH){1'b0}}};
    if (t0[31]) t0 = t0 - 34'sd4294967296;
    zf = t0;
    state_nxt = state_r;
    step_nxt = step_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    neg_nxt = neg_r;
    spec_nxt = spec_r;
    s_nxt = s_r;
    c_nxt = c_r;
    done_nxt = 1'b0;
    xs = y_r >>> step_r;
    ys = x_r >>> step_r;
    rx = x_r + 34'sd8192;
    ry = y_r + 34'sd8192;
    cv = clampq(rx >>> 14);
    sv = clampq(ry >>> 14);
    xr = '0;
    yr = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt = 1'b0;
          if (zf > QUARTER) begin
            zf = zf - HALF;
            neg_nxt = 1'b1;
          end else if (zf < -QUARTER) begin
            zf = zf + HALF;
            neg_nxt = 1'b1;
          end
          z_nxt = zf;
          x_nxt = 34'sd652032874;
          y_nxt = '0;
          step_nxt = '0;
          if (zf == 34'sd0) spec_nxt = 2'd1;
          else if (zf == QUARTER) spec_nxt = 2'd2;
          else if (zf == -QUARTER) spec_nxt = 2'd3;
          else spec_nxt = 2'd0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (z_r >= 0) begin
          x_nxt = x_r - xs;
          y_nxt = y_r + ys;
          z_nxt = z_r - arc_of(step_r);
        end else begin
          x_nxt = x_r + xs;
          y_nxt = y_r - ys;
          z_nxt = z_r + arc_of(step_r);
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        case (spec_r)
          2'd1: begin xr = 34'sd65536; yr = '0; end
          2'd2: begin xr = '0; yr = 34'sd65536; end
          2'd3: begin xr = '0; yr = -34'sd65536; end
          default: begin xr = 34'(cv); yr = 34'(sv); end
        endcase
        c_nxt = neg_r ? -xr[17:0] : xr[17:0];
        s_nxt = neg_r ? -yr[17:0] : yr[17:0];
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    neg_r <= neg_nxt;
    spec_r <= spec_nxt;
    s_r <= s_nxt;
    c_r <= c_nxt;
  end

  assign done = done_r;
  assign sin_q16 = s_r;
  assign cos_q16 = c_r;
endmodule

// ----- sv/rtp3_matrix.sv -----
// rtp3_matrix: recomputes the nine rotation coefficients after an angle
// write, sequencing three CORDIC runs and then a product and a sum step for
// each coefficient in turn. Depends on rtp3_pkg and rtp3_cordic.
module rtp3_matrix import rtp3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  angle_t     angle_x,
  input  angle_t     angle_y,
  input  angle_t     angle_z,
  output mat_stat_t  stat,
  output coef_t      coef [9]
);
  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_TRIG = 5'b00010,
    M_WAIT = 5'b00100,
    M_PROD = 5'b01000,
    M_SUM  = 5'b10000
  } mst_t;

  mst_t state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;         // which angle is in the CORDIC
  logic [3:0] ci_r, ci_nxt;         // coefficient being formed
  logic signed [17:0] sn_r [3], cs_r [3];
  coef_t coef_r [9];
  logic signed [35:0] p1_r, p2_r;   // first-level products
  logic signed [17:0] m1b_r, m2b_r; // second factors
  logic neg2_r;
  logic cstart;
  angle_t cang;
  logic cdone;
  logic signed [17:0] csin, ccos;
  logic signed [17:0] a1, b1, c1, a2, b2, c2;
  logic n2;
  logic signed [53:0] q1, q2, qs, qr;
  coef_t cval;

  localparam logic signed [17:0] ONE = 18'sd65536;

  rtp3_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cang),
    .done(cdone), .sin_q16(csin), .cos_q16(ccos)
  );

  always_comb begin
    case (ax_r)
      2'd0: cang = angle_x;
      2'd1: cang = angle_y;
      default: cang = angle_z;
    endcase
  end

  // Terms per coefficient: a1*b1*c1 + (n2 ? -1 : 1) * a2*b2*c2.
  // Index 0 x, 1 y, 2 z.
  always_comb begin
    a1 = '0; b1 = '0; c1 = '0; a2 = '0; b2 = '0; c2 = '0; n2 = 1'b0;
    case (ci_r)
      4'd0: begin a1 = cs_r[2]; b1 = cs_r[1]; c1 = ONE; end
      4'd1: begin a1 = cs_r[2]; b1 = sn_r[1]; c1 = sn_r[0];
                  a2 = sn_r[2]; b2 = cs_r[0]; c2 = ONE; n2 = 1'b1; end
      4'd2: begin a1 = cs_r[2]; b1 = sn_r[1]; c1 = cs_r[0];
                  a2 = sn_r[2]; b2 = sn_r[0]; c2 = ONE; end
      4'd3: begin a1 = sn_r[2]; b1 = cs_r[1]; c1 = ONE; end
      4'd4: begin a1 = sn_r[2]; b1 = sn_r[1]; c1 = sn_r[0];
                  a2 = cs_r[2]; b2 = cs_r[0]; c2 = ONE; end
      4'd5: begin a1 = sn_r[2]; b1 = sn_r[1]; c1 = cs_r[0];
                  a2 = cs_r[2]; b2 = sn_r[0]; c2 = ONE; n2 = 1'b1; end
      4'd6: begin a1 = -sn_r[1]; b1 = ONE; c1 = ONE; end
      4'd7: begin a1 = cs_r[1]; b1 = sn_r[0]; c1 = ONE; end
      4'd8: begin a1 = cs_r[1]; b1 = cs_r[0]; c1 = ONE; end
      default: ;
    endcase
  end

  always_comb begin
    q1 = p1_r * m1b_r;
    q2 = p2_r * m2b_r;
    qs = neg2_r ? (q1 - q2) : (q1 + q2);
    qr = (qs + 54'sd2147483648) >>> 32;
    if (qr > 54'sd131071) cval = 18'sd131071;
    else if (qr < -54'sd131072) cval = -18'sd131072;
    else cval = qr[17:0];
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt = ax_r;
    ci_nxt = ci_r;
    cstart = 1'b0;
    case (state_r)
      M_IDLE: if (start) begin
        ax_nxt = 2'd0;
        state_nxt = M_TRIG;
      end
      M_TRIG: begin
        cstart = 1'b1;
        state_nxt = M_WAIT;
      end
      M_WAIT: if (cdone) begin
        if (ax_r == 2'd2) begin
          ci_nxt = '0;
          state_nxt = M_PROD;
        end else begin
          ax_nxt = ax_r + 2'd1;
          state_nxt = M_TRIG;
        end
      end
      M_PROD: state_nxt = M_SUM;
      M_SUM: begin
        if (ci_r == 4'd8) state_nxt = M_IDLE;
        else begin
          ci_nxt = ci_r + 4'd1;
          state_nxt = M_PROD;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      for (int i = 0; i < 9; i++) coef_r[i] <= (i % 4 == 0) ? ONE : '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == M_SUM) coef_r[ci_r] <= cval;
    end
    ax_r <= ax_nxt;
    ci_r <= ci_nxt;
    if (state_r == M_WAIT && cdone) begin
      sn_r[ax_r] <= csin;
      cs_r[ax_r] <= ccos;
    end
    p1_r <= a1 * b1;
    p2_r <= a2 * b2;
    m1b_r <= c1;
    m2b_r <= c2;
    neg2_r <= n2;
  end

  assign stat.busy = (state_r != M_IDLE) || start;
  assign stat.done = (state_r == M_SUM) && (ci_r == 4'd8);
  assign coef = coef_r;
endmodule

// ----- sv/rtp3_point_pipe.sv -----
// rtp3_point_pipe: four-stage stallable datapath for R*p + T with rounding
// and saturation. Depends on rtp3_pkg.
module rtp3_point_pipe import rtp3_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t px, py, pz,
  input  coef_t  coef [9],
  input  coord_t off [3],
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t wx, wy, wz,
  output logic   clip
);
  localparam int NST = 4;
  logic [NST-1:0] v_r;
  logic adv [NST];
  // stage 1: split inputs
  logic signed [16:0] hi1_r [3];
  logic signed [16:0] lo1_r [3];
  // stage 2: products
  logic signed [34:0] ph_r [9];
  logic signed [35:0] pl_r [9];
  // stage 3: row sums
  logic signed [38:0] sh_r [3];
  logic signed [38:0] sl_r [3];
  // stage 4: result
  coord_t w_r [3];
  logic clip_r;
  coord_t pin [3];
  logic signed [39:0] v4 [3];
  coord_t w4 [3];
  logic [2:0] c4;

  assign pin[0] = px;
  assign pin[1] = py;
  assign pin[2] = pz;

  // advance a stage when its output slot is empty or moving on
  assign adv[3] = !v_r[3] || out_ready;
  assign adv[2] = !v_r[2] || adv[3];
  assign adv[1] = !v_r[1] || adv[2];
  assign adv[0] = !v_r[0] || adv[1];
  assign in_ready = adv[0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v4[r] = 40'(sh_r[r]) + 40'(off[r]) +
              40'((sl_r[r] + 39'sd32768) >>> 16);
      c4[r] = (v4[r] > 40'sd2147483647) || (v4[r] < -40'sd2147483648);
      if (v4[r] > 40'sd2147483647) w4[r] = 32'sh7fffffff;
      else if (v4[r] < -40'sd2147483648) w4[r] = 32'sh80000000;
      else w4[r] = v4[r][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
      if (adv[3]) v_r[3] <= v_r[2];
    end
    if (adv[0]) begin
      for (int j = 0; j < 3; j++) begin
        hi1_r[j] <= {pin[j][31], pin[j][31:16]};
        lo1_r[j] <= {1'b0, pin[j][15:0]};
      end
    end
    if (adv[1]) begin
      for (int k = 0; k < 9; k++) begin
        ph_r[k] <= coef[k] * hi1_r[k % 3];
        pl_r[k] <= coef[k] * lo1_r[k % 3];
      end
    end
    if (adv[2]) begin
      for (int r = 0; r < 3; r++) begin
        sh_r[r] <= 39'(ph_r[3*r]) + 39'(ph_r[3*r+1]) + 39'(ph_r[3*r+2]);
        sl_r[r] <= 39'(pl_r[3*r]) + 39'(pl_r[3*r+1]) + 39'(pl_r[3*r+2]);
      end
    end
    if (adv[3]) begin
      for (int r = 0; r < 3; r++) w_r[r] <= w4[r];
      clip_r <= |c4;
    end
  end

  assign out_valid = v_r[3];
  assign wx = w_r[0];
  assign wy = w_r[1];
  assign wz = w_r[2];
  assign clip = clip_r;
endmodule
